/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock out of reset
`define ELSCH_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define ELSCH_NEVER(lbl, clk_i, rst_ni, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define ELSCH_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define ELSCH_NEVER(lbl, clk_i, rst_ni, expr, msg)

`endif

`endif

/* rtl/elsch_pkg.sv */
// types shared by the elevator scheduler modules
package elsch_pkg;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // handed from each floor cell to the one above it
  typedef struct packed {
    logic car_below;
    logic up_any;
    logic down_any;
  } link_t;

  // broadcast to every floor cell
  typedef struct packed {
    logic fire;
    logic is_tick;
    dir_t dir;
  } cell_ctl_t;

endpackage

/* rtl/elsch_if.sv */
// request and result channel interfaces
interface elsch_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] floor;

  modport source (output valid, output cmd, output floor, input ready);
  modport sink (input valid, input cmd, input floor, output ready);
endinterface

interface elsch_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] current_floor;
  logic [1:0] direction;
  logic       stopped;
  logic       already_here;

  modport source (output valid, output current_floor, output direction, output stopped,
                  output already_here, input ready);
  modport sink (input valid, input current_floor, input direction, input stopped,
                input already_here, output ready);
endinterface

/* rtl/elsch_cell.sv */
// one floor cell: up, down and deferred stop bits for a single floor
module elsch_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  elsch_pkg::cell_ctl_t  ctl,
  input  logic                  split,
  input  logic                  at_pos,
  input  logic                  req_sel,
  input  elsch_pkg::link_t      link_in,
  output elsch_pkg::link_t      link_out,
  output logic                  up_q,
  output logic                  down_q,
  output logic                  def_q,
  output logic                  up_nxt,
  output logic                  down_nxt,
  output logic                  def_nxt,
  output logic                  stop_hit
);

  logic up_r, down_r, def_r;
  logic dir_up, dir_down;
  logic above, below;
  logic up_c, down_c;

  assign dir_up   = (ctl.dir == elsch_pkg::DIR_UP);
  assign dir_down = (ctl.dir == elsch_pkg::DIR_DOWN);
  assign above    = link_in.car_below;
  assign below    = !link_in.car_below && !at_pos;

  // clear on arrival, ripple emptiness upward
  always_comb begin
    up_c     = up_r && !(ctl.is_tick && dir_up && at_pos);
    down_c   = down_r && !(ctl.is_tick && dir_down && at_pos);
    stop_hit = ctl.is_tick && at_pos && ((dir_up && up_r) || (dir_down && down_r));
    link_out.car_below = link_in.car_below || at_pos;
    link_out.up_any    = link_in.up_any || up_c;
    link_out.down_any  = link_in.down_any || down_c;
  end

  // new marks and deferred split
  always_comb begin
    up_nxt   = up_c || (req_sel && dir_up && above) || (split && def_r && above);
    down_nxt = down_c || (req_sel && dir_down && below) || (split && def_r && below);
    def_nxt  = (def_r && !split) ||
               (req_sel && ((dir_up && !above) || (dir_down && !below)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r   <= 1'b0;
      down_r <= 1'b0;
      def_r  <= 1'b0;
    end else if (ctl.fire) begin
      up_r   <= up_nxt;
      down_r <= down_nxt;
      def_r  <= def_nxt;
    end
  end

  assign up_q   = up_r;
  assign down_q = down_r;
  assign def_q  = def_r;

endmodule

/* rtl/elevator_look_scheduler.sv */
// top level: LOOK scheduler for one elevator car
//
//   channel   dir   payload                                         accepted when
//   in_chan   in    cmd, floor                                      valid && ready
//   out_chan  out   current_floor, direction, stopped, already_here valid && ready
//
// one transaction per cycle while out_chan is not stalled; its result is registered and shows the next cycle
// the critical path runs along the row of floor cells (position and emptiness ripple)
// in_chan.ready is high while the result register is empty or being drained
// synchronous reset puts the car at floor 0, idle, with every stop bit clear
`include "assert_macros.svh"

module elevator_look_scheduler #(
  parameter int FLOORS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  elsch_in_if.sink     in_chan,
  elsch_out_if.source  out_chan
);

  localparam int PW = $clog2(FLOORS);
  localparam int CW = (PW > 4) ? PW : 4;

  logic [PW-1:0]         car_r, car_nxt, car_mv, pos;
  elsch_pkg::dir_t       dir_r, dir_nxt, dir_req;
  logic                  fire, is_tick, here, req_valid;
  logic [CW-1:0]         floor_x, car_x, out_floor_x;
  logic [FLOORS-1:0]     pos_oh, req_oh;
  logic [FLOORS-1:0]     up_q, down_q, def_q, up_nxt, down_nxt, def_nxt, stop_vec;
  elsch_pkg::link_t      link [FLOORS+1];
  elsch_pkg::cell_ctl_t  ctl;
  logic                  split;
  logic                  out_valid_r, out_stop_r, out_here_r;
  logic [3:0]            out_floor_r;
  logic [1:0]            out_dir_r;

  assign fire    = in_chan.valid && in_chan.ready;
  assign is_tick = in_chan.cmd;
  assign floor_x = CW'(in_chan.floor);
  assign car_x   = CW'(car_r);

  assign here      = !is_tick && (floor_x == car_x);
  assign req_valid = !is_tick && !here && (int'(in_chan.floor) < FLOORS);
  assign dir_req   = (dir_r != elsch_pkg::DIR_IDLE) ? dir_r :
                     ((floor_x > car_x) ? elsch_pkg::DIR_UP : elsch_pkg::DIR_DOWN);

  always_comb begin
    car_mv = car_r;
    if (dir_r == elsch_pkg::DIR_UP && (|up_q) && car_r != PW'(FLOORS - 1)) begin
      car_mv = car_r + 1'b1;
    end else if (dir_r == elsch_pkg::DIR_DOWN && (|down_q) && car_r != '0) begin
      car_mv = car_r - 1'b1;
    end
  end

  assign pos     = is_tick ? car_mv : car_r;
  assign pos_oh  = {{(FLOORS-1){1'b0}}, 1'b1} << pos;
  assign req_oh  = req_valid ? ({{(FLOORS-1){1'b0}}, 1'b1} << in_chan.floor) : '0;
  assign car_nxt = is_tick ? car_mv : car_r;

  always_comb begin
    ctl.fire    = fire;
    ctl.is_tick = is_tick;
    ctl.dir     = is_tick ? dir_r : dir_req;
  end

  assign link[0] = '0;

  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    elsch_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .split    (split),
      .at_pos   (pos_oh[i]),
      .req_sel  (req_oh[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .up_q     (up_q[i]),
      .down_q   (down_q[i]),
      .def_q    (def_q[i]),
      .up_nxt   (up_nxt[i]),
      .down_nxt (down_nxt[i]),
      .def_nxt  (def_nxt[i]),
      .stop_hit (stop_vec[i])
    );
  end

  // reverse when the current direction has run dry
  assign split = is_tick &&
                 ((dir_r == elsch_pkg::DIR_UP && !link[FLOORS].up_any) ||
                  (dir_r == elsch_pkg::DIR_DOWN && !link[FLOORS].down_any));

  always_comb begin
    dir_nxt = dir_r;
    if (is_tick) begin
      if (dir_r == elsch_pkg::DIR_UP && !link[FLOORS].up_any) begin
        dir_nxt = elsch_pkg::DIR_DOWN;
      end else if (dir_r == elsch_pkg::DIR_DOWN && !link[FLOORS].down_any) begin
        dir_nxt = elsch_pkg::DIR_UP;
      end
      if (!((|up_nxt) || (|down_nxt) || (|def_nxt))) begin
        dir_nxt = elsch_pkg::DIR_IDLE;
      end
    end else if (req_valid) begin
      dir_nxt = dir_req;
    end
  end

  assign out_floor_x = CW'(car_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_r       <= '0;
      dir_r       <= elsch_pkg::DIR_IDLE;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      car_r       <= car_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_floor_r <= out_floor_x[3:0];
      out_dir_r   <= dir_nxt;
      out_stop_r  <= |stop_vec;
      out_here_r  <= here;
    end
  end

  assign in_chan.ready          = !out_valid_r || out_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.current_floor = out_floor_r;
  assign out_chan.direction     = out_dir_r;
  assign out_chan.stopped       = out_stop_r;
  assign out_chan.already_here  = out_here_r;

  `ELSCH_ASSERT(a_idle_empty, clk, rst_n,
    (dir_r == elsch_pkg::DIR_IDLE) |-> (up_q == '0 && down_q == '0 && def_q == '0),
    "idle car with pending stops")
  `ELSCH_NEVER(a_car_range, clk, rst_n, int'(car_r) > FLOORS - 1, "car outside the building")
  `ELSCH_NEVER(a_flags_excl, clk, rst_n, out_valid_r && out_stop_r && out_here_r,
    "stop and already-here together")
  `ELSCH_ASSERT(a_req_no_stop, clk, rst_n, (fire && !is_tick) |=> !out_stop_r,
    "request reported a stop")

endmodule

/* verif/elevator_look_scheduler_tb.sv */
// testbench for the LOOK elevator scheduler: predicts every result and checks it
module elevator_look_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLOORS = 16;
  localparam logic [3:0] TOP_FLOOR = 4'(FLOORS - 1);
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [3:0]      floor_now;
    elsch_pkg::dir_t dir;
    logic            stopped;
    logic            already_here;
  } car_status_t;

  logic clk;
  logic rst_n;

  elsch_in_if  in_chan ();
  elsch_out_if out_chan ();

  elevator_look_scheduler #(.FLOORS(FLOORS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predicted car state
  logic [3:0]      car_pos;
  elsch_pkg::dir_t car_dir;
  logic [15:0]     up_marks;
  logic [15:0]     down_marks;
  logic [15:0]     deferred_marks;

  car_status_t expected_status_q[$];
  int          error_count;
  int          send_gap_max;
  int          recv_gap_max;
  int          recv_hold_cycles;

  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // deferred marks move to the up or down set depending on the side of the car
  function automatic void split_deferred_marks();
    logic [15:0] below;
    logic [15:0] here_bit;
    here_bit = 16'd1 << car_pos;
    below = here_bit - 16'd1;
    up_marks |= deferred_marks & ~(below | here_bit);
    down_marks |= deferred_marks & below;
    deferred_marks = '0;
  endfunction

  function automatic car_status_t step_car(input logic cmd, input logic [3:0] floor);
    car_status_t status;
    logic stop;
    logic here;
    stop = 1'b0;
    here = 1'b0;
    if (cmd == CMD_REQUEST) begin
      if (floor == car_pos) begin
        here = 1'b1;
      end else begin
        if (car_dir == elsch_pkg::DIR_IDLE)
          car_dir = (floor > car_pos) ? elsch_pkg::DIR_UP : elsch_pkg::DIR_DOWN;
        if (car_dir == elsch_pkg::DIR_UP) begin
          if (floor > car_pos) up_marks[floor] = 1'b1;
          else deferred_marks[floor] = 1'b1;
        end else if (car_dir == elsch_pkg::DIR_DOWN) begin
          if (floor < car_pos) down_marks[floor] = 1'b1;
          else deferred_marks[floor] = 1'b1;
        end
      end
    end else begin
      if (car_dir == elsch_pkg::DIR_UP && up_marks != 0 && car_pos != TOP_FLOOR) begin
        car_pos = car_pos + 4'd1;
      end else if (car_dir == elsch_pkg::DIR_DOWN && down_marks != 0 && car_pos != 4'd0) begin
        car_pos = car_pos - 4'd1;
      end
      if (car_dir == elsch_pkg::DIR_UP && up_marks[car_pos]) begin
        up_marks[car_pos] = 1'b0;
        stop = 1'b1;
      end else if (car_dir == elsch_pkg::DIR_DOWN && down_marks[car_pos]) begin
        down_marks[car_pos] = 1'b0;
        stop = 1'b1;
      end
      if (car_dir == elsch_pkg::DIR_UP && up_marks == 0) begin
        car_dir = elsch_pkg::DIR_DOWN;
        split_deferred_marks();
      end else if (car_dir == elsch_pkg::DIR_DOWN && down_marks == 0) begin
        car_dir = elsch_pkg::DIR_UP;
        split_deferred_marks();
      end
      if (up_marks == 0 && down_marks == 0 && deferred_marks == 0)
        car_dir = elsch_pkg::DIR_IDLE;
    end
    status.floor_now = car_pos;
    status.dir = car_dir;
    status.stopped = stop;
    status.already_here = here;
    return status;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [3:0] floor);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.cmd = cmd;
    in_chan.floor = floor;
    do @(posedge clk); while (!in_chan.ready);
    expected_status_q.insert(expected_status_q.size(), step_car(cmd, floor));
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic send_request(input logic [3:0] floor);
    send_item(CMD_REQUEST, floor);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic wait_drained();
    while (expected_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side: per-transaction stalls plus an optional long hold-off
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(negedge clk);
    wait (rst_n);
    forever begin
      if (recv_hold_cycles > 0) begin
        out_chan.ready = 1'b0;
        repeat (recv_hold_cycles) @(negedge clk);
        recv_hold_cycles = 0;
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    car_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_status_q.size() == 0) begin
        report_error("result transaction with nothing expected");
      end else begin
        want = expected_status_q.pop_front();
        if (out_chan.current_floor !== want.floor_now)
          report_error($sformatf("current_floor got %0d want %0d",
                                 out_chan.current_floor, want.floor_now));
        if (out_chan.direction !== want.dir)
          report_error($sformatf("direction got %0d want %0d",
                                 out_chan.direction, want.dir));
        if (out_chan.stopped !== want.stopped)
          report_error($sformatf("stopped got %0b want %0b",
                                 out_chan.stopped, want.stopped));
        if (out_chan.already_here !== want.already_here)
          report_error($sformatf("already_here got %0b want %0b",
                                 out_chan.already_here, want.already_here));
      end
    end
  end

  task automatic test_idle_car();
    send_tick();
    send_request(4'd0);
    send_tick();
  endtask

  task automatic test_direction_changes();
    send_request(4'd2);
    send_request(4'd0);
    send_request(4'd2);
    send_tick();
    send_tick();
    send_request(4'd2);
    send_request(4'd3);
    send_request(4'd1);
    send_tick();
    send_tick();
    send_request(TOP_FLOOR);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_request(4'd0);
    send_request(4'd5);
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 200;
    send_gap_max = 0;
    repeat (30) begin
      if ($urandom_range(0, 1)) send_tick();
      else send_request(4'($urandom_range(0, 15)));
    end
    send_gap_max = 17;
  endtask

  // bursts of requests followed by runs of ticks so the car travels and reverses
  task automatic test_random_traffic(input int total);
    int sent;
    int burst;
    sent = 0;
    while (sent < total) begin
      if (sent % 200 < 20) begin
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
        recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      end
      burst = $urandom_range(1, 4);
      repeat (burst) send_request(4'($urandom_range(0, 15)));
      sent += burst;
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 8);
      repeat (burst) send_tick();
      sent += burst;
    end
    send_gap_max = 17;
    recv_gap_max = 17;
  endtask

  initial begin
    car_pos = '0;
    car_dir = elsch_pkg::DIR_IDLE;
    up_marks = '0;
    down_marks = '0;
    deferred_marks = '0;
    error_count = 0;
    send_gap_max = 17;
    recv_gap_max = 17;
    recv_hold_cycles = 0;
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_REQUEST;
    in_chan.floor = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_car();
    test_direction_changes();
    test_backpressure();
    test_random_traffic(2000);

    wait_drained();
    if (expected_status_q.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_status_q.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/elsch_pkg.sv
rtl/elsch_if.sv
rtl/elsch_cell.sv
rtl/elevator_look_scheduler.sv
verif/elevator_look_scheduler_tb.sv
